// ===== src/form_urlencoded_decoder_core_macros.svh =====
// assertion macros used by the checker file fud_checker.sv
`ifndef FORM_URLENCODED_DECODER_CORE_MACROS_SVH
`define FORM_URLENCODED_DECODER_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define FUD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, disabled during reset
`define FUD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== src/fud_pkg.sv =====
package fud_pkg;

    localparam int PAIR_W = 6;

    // one result transaction without its run marker
    typedef struct packed {
        logic       has_byte;
        logic [7:0] data_byte;
        logic       token_end;
        logic       token_kind;
    } entry_t;

    // all results caused by one input byte
    typedef struct packed {
        logic [1:0]        count;
        logic [PAIR_W-1:0] pair_index;
        entry_t [2:0]      entries;
    } bundle_t;

endpackage

// ===== src/fud_front.sv =====
module fud_front #(
    parameter int MAX_PAIRS = 40
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_ready,
    input  logic [7:0]       in_byte,
    input  logic             query_last,
    output logic             push,
    output fud_pkg::bundle_t push_data
);

    localparam logic [7:0] CH_EQ    = 8'h3d;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CASE_MASK = 8'hdf;
    localparam logic [7:0] TEN      = 8'd10;

    localparam logic [1:0] PH_NONE = 2'd0;
    localparam logic [1:0] PH_PCT  = 2'd1;
    localparam logic [1:0] PH_ONE  = 2'd2;

    localparam logic [fud_pkg::PAIR_W-1:0] PAIR_MAX = fud_pkg::PAIR_W'(MAX_PAIRS);

    logic [1:0]                 escape_phase_reg, escape_phase_next;
    logic [7:0]                 first_char_reg, first_char_next;
    logic [fud_pkg::PAIR_W-1:0] pair_count_reg, pair_count_next;

    logic [1:0]       phase;
    logic [7:0]       sub;
    logic [7:0]       hi_digit;
    logic [7:0]       decoded;
    logic             advance;
    logic             take;
    fud_pkg::bundle_t bundle;

    function automatic logic [7:0] digit_value(input logic [7:0] c);
        logic [7:0] v;
        begin
            if (c >= CH_A)
            begin
                v = (c & CASE_MASK) - CH_A + TEN;
            end
            else
            begin
                v = c - CH_ZERO;
            end
            return v;
        end
    endfunction

    // data and kind read as zero where they carry no meaning
    function automatic fud_pkg::entry_t mk(input logic hb, input logic [7:0] b,
                                           input logic te, input logic kind);
        fud_pkg::entry_t e;
        begin
            e.has_byte   = hb;
            e.data_byte  = hb ? b : 8'd0;
            e.token_end  = te;
            e.token_kind = te ? kind : 1'b0;
            return e;
        end
    endfunction

    assign take     = in_valid && in_ready;
    assign phase    = (escape_phase_reg == 2'd3) ? PH_NONE : escape_phase_reg;
    assign sub      = (in_byte == CH_PLUS) ? CH_SPACE : in_byte;
    assign hi_digit = digit_value(first_char_reg);
    assign decoded  = {hi_digit[3:0], 4'd0} + digit_value(sub);

    always_comb
    begin
        bundle            = '0;
        bundle.pair_index = pair_count_reg;
        advance           = 1'b0;
        escape_phase_next = phase;
        first_char_next   = first_char_reg;

        if (in_byte == CH_EQ || in_byte == CH_AMP)
        begin
            // pending escape goes out literally; last piece closes the token
            case (phase)
                PH_PCT:
                begin
                    bundle.entries[0] = mk(1'b1, CH_PCT, 1'b1, in_byte == CH_AMP);
                    bundle.count      = 2'd1;
                end
                PH_ONE:
                begin
                    bundle.entries[0] = mk(1'b1, CH_PCT, 1'b0, 1'b0);
                    bundle.entries[1] = mk(1'b1, first_char_reg, 1'b1, in_byte == CH_AMP);
                    bundle.count      = 2'd2;
                end
                default:
                begin
                    bundle.entries[0] = mk(1'b0, 8'd0, 1'b1, in_byte == CH_AMP);
                    bundle.count      = 2'd1;
                end
            endcase
            escape_phase_next = PH_NONE;
            if (in_byte == CH_AMP)
            begin
                advance = 1'b1;
            end
            else if (query_last)
            begin
                // trailing '=' closes an empty value
                bundle.entries[bundle.count] = mk(1'b0, 8'd0, 1'b1, 1'b1);
                bundle.count                 = bundle.count + 2'd1;
                advance                      = 1'b1;
            end
        end
        else
        begin
            case (phase)
                PH_PCT:
                begin
                    if (query_last)
                    begin
                        bundle.entries[0] = mk(1'b1, CH_PCT, 1'b0, 1'b0);
                        bundle.entries[1] = mk(1'b1, sub, 1'b1, 1'b1);
                        bundle.count      = 2'd2;
                        escape_phase_next = PH_NONE;
                    end
                    else
                    begin
                        first_char_next   = sub;
                        escape_phase_next = PH_ONE;
                    end
                end
                PH_ONE:
                begin
                    bundle.entries[0] = mk(1'b1, decoded, query_last, 1'b1);
                    bundle.count      = 2'd1;
                    escape_phase_next = PH_NONE;
                end
                default:
                begin
                    if (sub == CH_PCT && !query_last)
                    begin
                        escape_phase_next = PH_PCT;
                    end
                    else
                    begin
                        bundle.entries[0] = mk(1'b1, sub, query_last, 1'b1);
                        bundle.count      = 2'd1;
                    end
                end
            endcase
            if (query_last)
            begin
                advance           = 1'b1;
                escape_phase_next = PH_NONE;
            end
        end

        pair_count_next = pair_count_reg;
        if (advance && pair_count_reg < PAIR_MAX)
        begin
            pair_count_next = pair_count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_phase_reg <= PH_NONE;
            first_char_reg   <= 8'd0;
            pair_count_reg   <= '0;
        end
        else if (take)
        begin
            escape_phase_reg <= escape_phase_next;
            first_char_reg   <= first_char_next;
            pair_count_reg   <= pair_count_next;
        end
    end

    assign push      = take && (bundle.count != 2'd0);
    assign push_data = bundle;

endmodule

// ===== src/fud_queue.sv =====
module fud_queue #(
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  fud_pkg::bundle_t push_data,
    input  logic             pop,
    output logic             full,
    output logic             head_valid,
    output fud_pkg::bundle_t head_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    fud_pkg::bundle_t slots_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] fill_reg, fill_next;

    function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
        begin
            return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
        end
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign full       = (fill_reg == CW'(DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head_data  = slots_reg[rd_ptr_reg];

endmodule

// ===== src/fud_back.sv =====
module fud_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       head_valid,
    input  fud_pkg::bundle_t           head_data,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       has_byte,
    output logic [7:0]                 data_byte,
    output logic                       token_end,
    output logic                       token_kind,
    output logic [fud_pkg::PAIR_W-1:0] pair_index,
    output logic                       run_last
);

    logic [1:0]      idx_reg, idx_next;
    fud_pkg::entry_t cur;
    logic            fire;

    assign cur       = head_data.entries[idx_reg];
    assign out_valid = head_valid;
    assign fire      = out_valid && out_ready;
    assign run_last  = (idx_reg == head_data.count - 2'd1);
    assign pop       = fire && run_last;

    always_comb
    begin
        idx_next = idx_reg;
        if (fire)
        begin
            idx_next = run_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 2'd0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

    assign has_byte   = cur.has_byte;
    assign data_byte  = cur.data_byte;
    assign token_end  = cur.token_end;
    assign token_kind = cur.token_kind;
    assign pair_index = head_data.pair_index;

endmodule

// ===== src/form_urlencoded_decoder_core.sv =====
// form_urlencoded_decoder_core: streaming decoder for url-encoded query strings
// input channel (in_valid/in_ready): one raw byte per transaction, query_last
//   marks the final byte of the query
// output channel (out_valid/out_ready): one decoded result per transaction;
//   each input byte causes zero to three results, the last flagged by run_last
// the first result of a byte is written into the run queue when the byte is
//   taken and is offered from the queue head once the runs ahead of it are sent
// throughput: one byte per cycle while each byte yields at most one result
//   and out_ready stays high; bytes that yield two or three results are sent
//   one by one by the single-result-per-cycle output serializer
// a two-entry run queue sits between the byte classifier and the serializer,
//   so in_ready depends only on queue fill and never on out_ready
// when the receiver stalls, the queue fills and then in_ready drops; nothing
//   is lost and the offered result holds steady
// reset clears escape state, pair counter, queue pointers and the serializer
module form_urlencoded_decoder_core #(
    parameter int MAX_PAIRS   = 40,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [7:0]                 in_byte,
    input  logic                       query_last,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       has_byte,
    output logic [7:0]                 data_byte,
    output logic                       token_end,
    output logic                       token_kind,
    output logic [fud_pkg::PAIR_W-1:0] pair_index,
    output logic                       run_last
);

    logic             push;
    logic             pop;
    logic             full;
    logic             head_valid;
    fud_pkg::bundle_t push_data;
    fud_pkg::bundle_t head_data;

    // accept whenever the run queue has room
    assign in_ready = !full;

    // classifier: escape tracking, token ends and pair counting
    fud_front #(
        .MAX_PAIRS (MAX_PAIRS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .query_last (query_last),
        .push       (push),
        .push_data  (push_data)
    );

    // runs of results waiting for the serializer
    fud_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    // serializer: one result transaction per cycle while the queue holds a run and out_ready is high
    fud_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .has_byte   (has_byte),
        .data_byte  (data_byte),
        .token_end  (token_end),
        .token_kind (token_kind),
        .pair_index (pair_index),
        .run_last   (run_last)
    );

endmodule

// ===== src/fud_checker.sv =====
`include "form_urlencoded_decoder_core_macros.svh"

module fud_checker #(
    parameter int MAX_PAIRS = 40
) (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic                       has_byte,
    input logic [7:0]                 data_byte,
    input logic                       token_end,
    input logic                       token_kind,
    input logic [fud_pkg::PAIR_W-1:0] pair_index,
    input logic                       run_last
);

    // a stalled result stays offered
    `FUD_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid)

    // the rest of a run follows without a gap
    `FUD_ASSERT_NEXT(a_run_gapless, clk, rst_n, out_valid && out_ready && !run_last, out_valid)

    // no data byte means a zero data field
    `FUD_ASSERT_NOW(a_empty_zero, clk, rst_n, out_valid && !has_byte, data_byte == 8'd0)

    // kind only carries meaning at a token end
    `FUD_ASSERT_NOW(a_kind_zero, clk, rst_n, out_valid && !token_end, token_kind == 1'b0)

    // pair index saturates at the limit
    `FUD_ASSERT_NOW(a_pair_sat, clk, rst_n, out_valid,
                    pair_index <= fud_pkg::PAIR_W'(MAX_PAIRS))

endmodule

bind form_urlencoded_decoder_core fud_checker #(
    .MAX_PAIRS (MAX_PAIRS)
) u_fud_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .has_byte   (has_byte),
    .data_byte  (data_byte),
    .token_end  (token_end),
    .token_kind (token_kind),
    .pair_index (pair_index),
    .run_last   (run_last)
);

// ===== tb/sv/decoded_stream_checker.sv =====
`timescale 1ns / 100ps

module decoded_stream_checker #(
    parameter int MAX_PAIRS = 40
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic [7:0]                 in_byte,
    input  logic                       query_last,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic                       has_byte,
    input  logic [7:0]                 data_byte,
    input  logic                       token_end,
    input  logic                       token_kind,
    input  logic [fud_pkg::PAIR_W-1:0] pair_index,
    input  logic                       run_last,
    output int                         mismatch_count,
    output int                         pending_count
);

    localparam logic [7:0] CH_EQUALS  = 8'h3d;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_PLUS    = 8'h2b;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CASE_MASK  = 8'hdf;
    localparam logic [7:0] HEX_OFFSET = 8'd10;
    localparam logic [7:0] HEX_RADIX  = 8'd16;
    localparam logic       KIND_NAME  = 1'b0;
    localparam logic       KIND_VALUE = 1'b1;

    typedef enum logic [1:0] {
        ESC_NONE,
        ESC_PERCENT,
        ESC_DIGIT
    } escape_phase_t;

    typedef struct packed {
        logic                       has_byte;
        logic [7:0]                 data_byte;
        logic                       token_end;
        logic                       token_kind;
        logic [fud_pkg::PAIR_W-1:0] pair_index;
        logic                       run_last;
    } decoded_t;

    decoded_t                   expected_decodes[$];
    escape_phase_t              esc_phase;
    logic [7:0]                 first_digit;
    logic [fud_pkg::PAIR_W-1:0] pairs_done;
    int                         byte_results;

    function automatic logic [7:0] hex_value(logic [7:0] c);
        if (c >= CH_UPPER_A)
            return (c & CASE_MASK) - CH_UPPER_A + HEX_OFFSET;
        return c - CH_ZERO;
    endfunction

    function void push_result(logic hb, logic [7:0] b, logic te, logic kind);
        decoded_t r;
        r.has_byte   = hb;
        r.data_byte  = hb ? b : 8'd0;
        r.token_end  = te;
        r.token_kind = te ? kind : 1'b0;
        r.pair_index = pairs_done;
        r.run_last   = 1'b0;
        expected_decodes.insert(expected_decodes.size(), r);
        byte_results++;
    endfunction

    function void count_pair();
        if (pairs_done < MAX_PAIRS)
            pairs_done = pairs_done + 1'b1;
    endfunction

    // a separator cuts a pending escape: its characters come out as data
    function bit flush_escape(logic kind);
        bit ended;
        ended = 1'b0;
        case (esc_phase)
            ESC_PERCENT:
            begin
                push_result(1'b1, CH_PERCENT, 1'b1, kind);
                ended = 1'b1;
            end
            ESC_DIGIT:
            begin
                push_result(1'b1, CH_PERCENT, 1'b0, KIND_NAME);
                push_result(1'b1, first_digit, 1'b1, kind);
                ended = 1'b1;
            end
            default:
            begin
            end
        endcase
        esc_phase = ESC_NONE;
        return ended;
    endfunction

    function void decode_byte(logic [7:0] raw, logic last);
        logic [7:0] s;
        logic [7:0] merged;
        byte_results = 0;
        if (raw == CH_EQUALS)
        begin
            if (!flush_escape(KIND_NAME))
                push_result(1'b0, 8'd0, 1'b1, KIND_NAME);
            // trailing '=' closes an empty value too
            if (last)
            begin
                push_result(1'b0, 8'd0, 1'b1, KIND_VALUE);
                count_pair();
            end
        end
        else if (raw == CH_AMP)
        begin
            if (!flush_escape(KIND_VALUE))
                push_result(1'b0, 8'd0, 1'b1, KIND_VALUE);
            count_pair();
        end
        else
        begin
            s = (raw == CH_PLUS) ? CH_SPACE : raw;
            case (esc_phase)
                ESC_NONE:
                begin
                    if (s == CH_PERCENT && !last)
                        esc_phase = ESC_PERCENT;
                    else
                        push_result(1'b1, s, last, KIND_VALUE);
                end
                ESC_PERCENT:
                begin
                    if (last)
                    begin
                        push_result(1'b1, CH_PERCENT, 1'b0, KIND_NAME);
                        push_result(1'b1, s, 1'b1, KIND_VALUE);
                        esc_phase = ESC_NONE;
                    end
                    else
                    begin
                        first_digit = s;
                        esc_phase   = ESC_DIGIT;
                    end
                end
                default:
                begin
                    merged = hex_value(first_digit) * HEX_RADIX + hex_value(s);
                    push_result(1'b1, merged, last, KIND_VALUE);
                    esc_phase = ESC_NONE;
                end
            endcase
            if (last)
            begin
                count_pair();
                esc_phase = ESC_NONE;
            end
        end
        if (byte_results > 0)
            expected_decodes[expected_decodes.size()-1].run_last = 1'b1;
    endfunction

    task automatic compare_field(string field, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_result();
        decoded_t want;
        if (expected_decodes.size() == 0)
        begin
            $error("output transaction with nothing expected");
            mismatch_count++;
        end
        else
        begin
            want = expected_decodes.pop_front();
            compare_field("has_byte", want.has_byte, has_byte);
            compare_field("data_byte", want.data_byte, data_byte);
            compare_field("token_end", want.token_end, token_end);
            compare_field("token_kind", want.token_kind, token_kind);
            compare_field("pair_index", want.pair_index, pair_index);
            compare_field("run_last", want.run_last, run_last);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_phase   = ESC_NONE;
            first_digit = 8'd0;
            pairs_done  = '0;
            expected_decodes.delete();
            pending_count  = 0;
            mismatch_count = 0;
        end
        else
        begin
            // results of this edge come from older bytes, so check first
            if (out_valid && out_ready)
                check_result();
            if (in_valid && in_ready)
                decode_byte(in_byte, query_last);
            pending_count = expected_decodes.size();
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    localparam int MAX_PAIRS   = 40;
    localparam int HOLD_CYCLES = 60;
    localparam int DRAIN_TAIL  = 5;

    // characters the query generator builds from
    localparam logic [7:0] CH_EQUALS  = 8'h3d;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_PLUS    = 8'h2b;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_ZERO    = 8'h30;

    localparam string HEX_DIGITS = "0123456789abcdefABCDEF";

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic [7:0]                 in_byte = 8'd0;
    logic                       query_last = 1'b0;
    logic                       out_valid;
    logic                       out_ready;
    logic                       has_byte;
    logic [7:0]                 data_byte;
    logic                       token_end;
    logic                       token_kind;
    logic [fud_pkg::PAIR_W-1:0] pair_index;
    logic                       run_last;

    int mismatch_count;
    int pending_count;

    // shared pacing controls between the two sides
    bit back_to_back  = 1'b0;
    bit hold_requested = 1'b0;

    int         items_sent = 0;
    logic [7:0] query_bytes[$];

    always #5 clk = ~clk;

    form_urlencoded_decoder_core #(
        .MAX_PAIRS(MAX_PAIRS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .query_last(query_last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .has_byte  (has_byte),
        .data_byte (data_byte),
        .token_end (token_end),
        .token_kind(token_kind),
        .pair_index(pair_index),
        .run_last  (run_last)
    );

    decoded_stream_checker #(
        .MAX_PAIRS(MAX_PAIRS)
    ) checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_byte       (in_byte),
        .query_last    (query_last),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .has_byte      (has_byte),
        .data_byte     (data_byte),
        .token_end     (token_end),
        .token_kind    (token_kind),
        .pair_index    (pair_index),
        .run_last      (run_last),
        .mismatch_count(mismatch_count),
        .pending_count (pending_count)
    );

    // offer one byte, called and returning at a falling edge
    task automatic send_item(logic [7:0] raw, logic last);
        int gap;
        gap = back_to_back ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        in_byte    <= raw;
        query_last <= last;
        // hold the transaction until the block takes it
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        items_sent++;
    endtask

    function automatic logic [7:0] pick_hex();
        return HEX_DIGITS[$urandom_range(0, 21)];
    endfunction

    function automatic logic [7:0] pick_plain();
        case ($urandom_range(0, 2))
            0:       return CH_LOWER_A + 8'($urandom_range(0, 25));
            1:       return CH_UPPER_A + 8'($urandom_range(0, 25));
            default: return CH_ZERO + 8'($urandom_range(0, 9));
        endcase
    endfunction

    // append one byte to the query under construction
    function automatic void add_byte(logic [7:0] b);
        query_bytes.insert(query_bytes.size(), b);
    endfunction

    // one name or value token, mostly plain text and proper escapes
    function automatic void append_token(int pieces);
        for (int i = 0; i < pieces; i++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4:
                    add_byte(pick_plain());
                5:
                    add_byte(CH_PLUS);
                6, 7:
                begin
                    add_byte(CH_PERCENT);
                    add_byte(pick_hex());
                    add_byte(pick_hex());
                end
                8:
                begin
                    // escape cut short by whatever follows the token
                    add_byte(CH_PERCENT);
                    if ($urandom_range(0, 1))
                        add_byte(pick_hex());
                    return;
                end
                default:
                    add_byte(8'($urandom_range(0, 255)));
            endcase
        end
    endfunction

    // a whole query string, the final byte flagged as last
    task automatic send_query();
        int pair_total;
        pair_total = $urandom_range(1, 3);
        query_bytes.delete();
        for (int p = 0; p < pair_total; p++)
        begin
            append_token($urandom_range(0, 3));
            add_byte(CH_EQUALS);
            append_token($urandom_range(0, 4));
            if (p < pair_total - 1)
                add_byte(CH_AMP);
        end
        case ($urandom_range(0, 5))
            0:
                add_byte(CH_AMP);
            1:
            begin
                // name with trailing '=' and no value
                add_byte(CH_AMP);
                append_token($urandom_range(0, 2));
                add_byte(CH_EQUALS);
            end
            default:
            begin
            end
        endcase
        for (int i = 0; i < query_bytes.size(); i++)
            send_item(query_bytes[i], i == query_bytes.size() - 1);
    endtask

    task automatic random_unit();
        if ($urandom_range(0, 9) < 2)
            send_item(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        else
            send_query();
    endtask

    // every one of these ends a value and so advances the pair counter
    task automatic send_value_end();
        case ($urandom_range(0, 2))
            0:       send_item(CH_AMP, 1'($urandom_range(0, 1)));
            1:       send_item(CH_EQUALS, 1'b1);
            default: send_item(8'($urandom_range(0, 255)), 1'b1);
        endcase
    endtask

    // receiver: random stall per result, one long hold-off on request
    initial
    begin
        int wait_cycles;
        bit hold_done;
        hold_done = 1'b0;
        out_ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            wait_cycles = back_to_back ? 0 : $urandom_range(0, 3);
            if (hold_requested && !hold_done)
            begin
                hold_done   = 1'b1;
                wait_cycles = HOLD_CYCLES;
            end
            if (wait_cycles > 0)
            begin
                out_ready <= 1'b0;
                repeat (wait_cycles) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // sender and verdict
    initial
    begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // directed: name with '+', then an escape decoding to 'A'
        send_item(8'h61, 1'b0);
        send_item(CH_PLUS, 1'b0);
        send_item(CH_EQUALS, 1'b0);
        send_item(CH_PERCENT, 1'b0);
        send_item(8'h34, 1'b0);
        send_item(8'h31, 1'b0);
        // lone '%' cut by '&'
        send_item(CH_PERCENT, 1'b0);
        send_item(CH_AMP, 1'b0);
        // '%' and one digit cut by '='
        send_item(CH_PERCENT, 1'b0);
        send_item(8'h66, 1'b0);
        send_item(CH_EQUALS, 1'b0);
        // escape made of non-hex characters
        send_item(CH_PERCENT, 1'b0);
        send_item(8'h7a, 1'b0);
        send_item(8'h5a, 1'b0);
        // '%' and one digit cut by '&'
        send_item(CH_PERCENT, 1'b0);
        send_item(8'h37, 1'b0);
        send_item(CH_AMP, 1'b0);
        // byte extremes, then trailing '=' on the last byte
        send_item(8'h00, 1'b0);
        send_item(8'hff, 1'b0);
        send_item(CH_EQUALS, 1'b1);
        // escape left incomplete by the last byte
        send_item(CH_PERCENT, 1'b0);
        send_item(CH_PLUS, 1'b1);
        // trailing '&', '%' as the last byte, plain last byte
        send_item(CH_AMP, 1'b1);
        send_item(CH_PERCENT, 1'b1);
        send_item(8'h78, 1'b1);

        // random queries; the receiver stalls long early on so the block backs up
        hold_requested = 1'b1;
        while (items_sent < 50)
            random_unit();

        // back-to-back burst that drives the pair counter into saturation
        back_to_back = 1'b1;
        repeat (45) send_value_end();
        back_to_back = 1'b0;

        while (items_sent < 100)
            random_unit();
        in_valid <= 1'b0;

        // drain, then let the block settle
        wait (pending_count == 0);
        repeat (DRAIN_TAIL) @(posedge clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
